// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the blur/sharpen core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock outside reset
`define BBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// expression must never be true outside reset
`define BBS_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

// File: rtl/core/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants for the 3x3 blur/sharpen core.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;

    // floor(x/9) == (x * RECIP_9) >> RECIP_SHIFT for x < 4096
    localparam logic [SUM_W-1:0] RECIP_9 = 12'd3641;
    localparam int RECIP_SHIFT = 15;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic                is_flush;
        logic [COLSUM_W-1:0] col_sum;
        logic [PIX_W-1:0]    mid;
        logic                emit_main;
        logic                interior;
        logic                emit_edge;
        logic                eof;
    } bbs_entry_t;

    typedef struct packed {
        logic              not_empty;
        logic [QCNT_W-1:0] count;
    } bbs_qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/bbs_ram.sv
// ----------------------------------------------------------------------------
// bbs_ram
// Simple dual-port RAM, one write and one registered read, read-old on clash.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bbs_queue.sv
// ----------------------------------------------------------------------------
// bbs_queue
// Short FIFO between the classifying front end and the filter back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bbs_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire bbs_pkg::bbs_entry_t push_data,
    input  wire logic                pop,
    output bbs_pkg::bbs_entry_t      head,
    output bbs_pkg::bbs_qstat_t      stat
);
    import bbs_pkg::*;

    bbs_entry_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.count     = count_reg;

    `BBS_NEVER(a_q_overflow, push && !pop && (count_reg == QCNT_W'(QDEPTH)), "queue overflow")
    `BBS_NEVER(a_q_underflow, pop && (count_reg == '0), "queue underflow")

endmodule

`default_nettype wire

// File: rtl/core/bbs_front.sv
// ----------------------------------------------------------------------------
// bbs_front
// Accepts pixels and flushes, tracks frame position, owns the line stores
// and hands classified items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bbs_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bbs_pkg::PIX_W-1:0]  s_tdata,
    input  wire logic                       s_tuser,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [bbs_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                            push,
    output bbs_pkg::bbs_entry_t             push_data,
    input  wire bbs_pkg::bbs_qstat_t        qstat
);
    import bbs_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW  = (SW > CFG_W) ? SW : CFG_W;
    localparam int CMPH  = (HW > CFG_W) ? HW : CFG_W;
    localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    logic [SW-1:0]   width_reg, width_next;
    logic [HW-1:0]   height_reg, height_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [SW-1:0]   pend_reg, pend_next;
    logic [CMPW-1:0] wval;
    logic [CMPH-1:0] hval;

    logic            accept, px_acc, fl_acc;
    logic            last_col, last_row;
    logic [CW-1:0]   fl_col, rd_addr;

    logic [PIX_W-1:0] up_rdata, mid_rdata, up_val;

    logic             f1_valid_reg;
    logic             f1_flush_reg;
    logic [CW-1:0]    f1_col_reg;
    logic [PIX_W-1:0] f1_px_reg;
    logic             f1_main_reg, f1_int_reg, f1_edge_reg, f1_eof_reg;
    logic             f1_hit_reg;
    logic [PIX_W-1:0] f1_byp_reg;

    // credit covers the beat still in the read stage
    assign s_tready = ({1'b0, qstat.count} + (QCNT_W + 1)'(f1_valid_reg))
                      < (QCNT_W + 1)'(QDEPTH);
    assign accept   = s_tvalid && s_tready;
    assign px_acc   = accept && (s_tuser == KIND_PIXEL);
    assign fl_acc   = accept && (s_tuser == KIND_FLUSH) && (pend_reg != '0);

    assign last_col = (SW'(col_reg) == width_reg - SW'(1));
    assign last_row = (HW'(row_reg) == height_reg - HW'(1));
    assign fl_col   = CW'(width_reg - pend_reg);
    assign rd_addr  = px_acc ? col_reg : fl_col;

    always_comb begin
        wval = CMPW'(cfg_wdata);
        hval = CMPH'(cfg_wdata);
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    if (wval == '0) begin
                        width_next = SW'(1);
                    end else if (wval > CMPW'(MAX_WIDTH)) begin
                        width_next = SW'(MAX_WIDTH);
                    end else begin
                        width_next = SW'(wval);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (hval == '0) begin
                        height_next = HW'(1);
                    end else if (hval > CMPH'(MAX_HEIGHT)) begin
                        height_next = HW'(MAX_HEIGHT);
                    end else begin
                        height_next = HW'(hval);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        if (cfg_we) begin
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
        end else if (px_acc) begin
            pend_next = '0;
            if (last_col) begin
                col_next = '0;
                if (last_row) begin
                    row_next  = '0;
                    pend_next = width_reg;
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end else if (fl_acc) begin
            pend_next = pend_reg - SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= SW'(RST_W);
            height_reg   <= HW'(RST_H);
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
            f1_valid_reg <= px_acc || fl_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_flush_reg <= !px_acc;
            f1_col_reg   <= col_reg;
            f1_px_reg    <= s_tdata;
            f1_main_reg  <= (row_reg != '0) && (col_reg != '0);
            f1_int_reg   <= (row_reg > RW'(1)) && (col_reg > CW'(1));
            f1_edge_reg  <= (row_reg != '0) && last_col;
            f1_eof_reg   <= (pend_reg == SW'(1));
            // upper store write of the previous beat lands on this read
            f1_hit_reg   <= f1_valid_reg && !f1_flush_reg && (f1_col_reg == col_reg);
            f1_byp_reg   <= mid_rdata;
        end
    end

    bbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_ram (
        .aclk  (aclk),
        .we    (px_acc),
        .waddr (col_reg),
        .wdata (s_tdata),
        .re    (px_acc || fl_acc),
        .raddr (rd_addr),
        .rdata (mid_rdata)
    );

    bbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_up_ram (
        .aclk  (aclk),
        .we    (f1_valid_reg && !f1_flush_reg),
        .waddr (f1_col_reg),
        .wdata (mid_rdata),
        .re    (px_acc),
        .raddr (col_reg),
        .rdata (up_rdata)
    );

    assign up_val = f1_hit_reg ? f1_byp_reg : up_rdata;

    assign push               = f1_valid_reg;
    assign push_data.is_flush = f1_flush_reg;
    assign push_data.col_sum  = COLSUM_W'(up_val) + COLSUM_W'(mid_rdata)
                                + COLSUM_W'(f1_px_reg);
    assign push_data.mid       = mid_rdata;
    assign push_data.emit_main = f1_main_reg;
    assign push_data.interior  = f1_int_reg;
    assign push_data.emit_edge = f1_edge_reg;
    assign push_data.eof       = f1_eof_reg;

    `BBS_ASSERT(a_pend_range, pend_reg <= width_reg, "pending count beyond row width")

endmodule

`default_nettype wire

// File: rtl/core/bbs_back.sv
// ----------------------------------------------------------------------------
// bbs_back
// Window column sums, divide by nine, sharpen, and result serialisation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bbs_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bbs_pkg::bbs_qstat_t          qstat,
    input  wire bbs_pkg::bbs_entry_t          head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [2*bbs_pkg::PIX_W-1:0]       m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);
    import bbs_pkg::*;

    // window: column sums of the two older columns and the centre pixel
    logic [COLSUM_W-1:0] cs0_reg, cs1_reg;
    logic [PIX_W-1:0]    centre_reg;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_flush_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [PIX_W-1:0]    s1_src_reg, s1_mid_reg;
    logic                s1_main_reg, s1_int_reg, s1_edge_reg, s1_eof_reg;

    logic                s2_valid_reg, s2_valid_next;
    logic                s2_has0_reg, s2_has1_reg, s2_done0_reg;
    logic [PIX_W-1:0]    s2_blur0_reg, s2_sharp0_reg, s2_val1_reg;
    logic                s2_eof1_reg;

    logic                m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]    m_blur_reg, m_sharp_reg;
    logic                m_eof_reg, m_last_reg;

    logic                out_free, take0, take1, s2_done, s2_free, s1_adv, s1_free;
    logic [2*SUM_W-1:0]  prod;
    logic [PIX_W-1:0]    blur, sharp;

    assign out_free = !m_valid_reg || m_tready;
    assign take0    = s2_valid_reg && out_free && s2_has0_reg && !s2_done0_reg;
    assign take1    = s2_valid_reg && out_free && s2_has1_reg
                      && (!s2_has0_reg || s2_done0_reg);
    assign s2_done  = s2_valid_reg && ((!s2_has0_reg && !s2_has1_reg) || take1
                      || (take0 && !s2_has1_reg));
    assign s2_free  = !s2_valid_reg || s2_done;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign pop      = qstat.not_empty && s1_free;

    assign s1_valid_next = pop || (s1_valid_reg && !s1_adv);
    assign s2_valid_next = s1_adv || (s2_valid_reg && !s2_done);
    assign m_valid_next  = take0 || take1 || (m_valid_reg && !m_tready);

    assign prod  = s1_sum_reg * RECIP_9;
    assign blur  = s1_int_reg ? prod[RECIP_SHIFT +: PIX_W] : s1_src_reg;
    assign sharp = {s1_src_reg[PIX_W-3:0], 2'b00} - blur - {blur[PIX_W-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs0_reg      <= '0;
            cs1_reg      <= '0;
            centre_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_done0_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (pop && !head.is_flush) begin
                cs0_reg    <= cs1_reg;
                cs1_reg    <= head.col_sum;
                centre_reg <= head.mid;
            end
            if (s2_done) begin
                s2_done0_reg <= 1'b0;
            end else if (take0) begin
                s2_done0_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_flush_reg <= head.is_flush;
            s1_sum_reg   <= SUM_W'(cs0_reg) + SUM_W'(cs1_reg) + SUM_W'(head.col_sum);
            s1_src_reg   <= centre_reg;
            s1_mid_reg   <= head.mid;
            s1_main_reg  <= head.emit_main;
            s1_int_reg   <= head.interior;
            s1_edge_reg  <= head.emit_edge;
            s1_eof_reg   <= head.eof;
        end
        if (s1_adv) begin
            s2_has0_reg   <= !s1_flush_reg && s1_main_reg;
            s2_has1_reg   <= s1_flush_reg || s1_edge_reg;
            s2_blur0_reg  <= blur;
            s2_sharp0_reg <= sharp;
            s2_val1_reg   <= s1_mid_reg;
            s2_eof1_reg   <= s1_flush_reg && s1_eof_reg;
        end
        if (take0) begin
            m_blur_reg  <= s2_blur0_reg;
            m_sharp_reg <= s2_sharp0_reg;
            m_eof_reg   <= 1'b0;
            m_last_reg  <= !s2_has1_reg;
        end else if (take1) begin
            // border result: blur equals source, so sharp equals source too
            m_blur_reg  <= s2_val1_reg;
            m_sharp_reg <= s2_val1_reg;
            m_eof_reg   <= s2_eof1_reg;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_sharp_reg, m_blur_reg};
    assign m_tlast  = m_eof_reg;
    assign m_tuser  = m_last_reg;

    `BBS_ASSERT(a_done0_pair, s2_done0_reg |-> (s2_valid_reg && s2_has1_reg), "stray done flag")

endmodule

`default_nettype wire

// File: rtl/core/box_blur_sharpen_3x3_top.sv
// ----------------------------------------------------------------------------
// box_blur_sharpen_3x3_top
// 3x3 box blur with unsharp-mask sharpening on a raster pixel stream.
// ----------------------------------------------------------------------------
// Input stream: one beat per pixel in raster order, s_tuser low, s_tdata the
// pixel. A beat with s_tuser high is a flush: after a frame's last pixel it
// releases one result of the held-back bottom row, otherwise it is swallowed.
// Output stream: one row behind the input, m_tdata carries blur and sharp,
// m_tlast marks the frame's final pixel, m_tuser the last result of a beat.
// Frame width and height are set through cfg_we/cfg_index/cfg_wdata while
// the core is idle; a write restarts the frame position.
// Throughput: one input beat per clock. A beat at a row end yields two
// results, so the output port sets the pace there; the input is held off
// by the four-entry queue between front and back end.
// Pipeline: an accepted beat passes the line-store read, queue, window sum,
// divide-by-nine multiply and output register in turn before m_tvalid rises.
// Reset: frame size returns to 256 x 256, position and pending row clear;
// line stores are not cleared. When m_tready is low results wait in the
// output register and back end, then the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_sharpen_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bbs_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
    input  wire logic                          s_tuser,   // [0] kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [2*bbs_pkg::PIX_W-1:0]        m_tdata,   // [7:0] blur, [15:8] sharp
    output logic                               m_tlast,
    output logic                               m_tuser,   // [0] last_of_run
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [bbs_pkg::CFG_W-1:0]     cfg_wdata
);
    import bbs_pkg::*;

    logic       push, pop;
    bbs_entry_t push_data, head;
    bbs_qstat_t qstat;

    bbs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_data (push_data),
        .qstat     (qstat)
    );

    bbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    bbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
